[hw/rtl/thin_line_removal_filter_assert.svh]
// ----------------------------------------------------------------------------
// Thin line removal filter: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef THIN_LINE_REMOVAL_FILTER_ASSERT_SVH
`define THIN_LINE_REMOVAL_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define TLR_ASSERT_IMP(lbl, clock, rst_n, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TLR_ASSERT_NXT(lbl, clock, rst_n, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TLR_ASSERT_IMP(lbl, clock, rst_n, ante, cons)
`define TLR_ASSERT_NXT(lbl, clock, rst_n, ante, cons)
`endif

`endif

[hw/rtl/tlr_pkg.sv]
// ----------------------------------------------------------------------------
// Thin line removal filter package
// Shared widths, register indexes, reset values and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package tlr_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int COLOR_W       = 24;
	localparam int WIDTH_REG_W   = 13;
	localparam int HEIGHT_W      = 16;
	localparam int CFG_ADDR_W    = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FILTER_ENABLE = 2'd2;

	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [HEIGHT_W-1:0]    HEIGHT_RST = 16'd480;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef struct packed {
		logic produce;
		logic vert;
		logic interior;
		logic wr_raw;
		logic eoi;
	} tlr_step_t;

endpackage

`default_nettype wire

[hw/rtl/tlr_in_if.sv]
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one pixel or drain item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlr_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [tlr_pkg::COLOR_W-1:0] pixel_color;

	modport source (output valid, action, pixel_color, input ready);
	modport sink (input valid, action, pixel_color, output ready);
endinterface

`default_nettype wire

[hw/rtl/tlr_out_if.sv]
// ----------------------------------------------------------------------------
// Filtered pixel output channel
// Valid/ready channel carrying one filtered pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlr_out_if;
	logic                        valid;
	logic                        ready;
	logic [tlr_pkg::COLOR_W-1:0] out_color;
	logic                        end_of_image;

	modport source (output valid, out_color, end_of_image, input ready);
	modport sink (input valid, out_color, end_of_image, output ready);
endinterface

`default_nettype wire

[hw/rtl/tlr_line_ram.sv]
// ----------------------------------------------------------------------------
// Line buffer RAM
// One write port, one registered read port, write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_line_ram #(
	parameter int DEPTH  = tlr_pkg::MAX_WIDTH_DEF,
	parameter int DATA_W = tlr_pkg::COLOR_W
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] byp_data_q;
	logic              byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q       <= mem[raddr];
		byp_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (waddr == raddr);
		end
	end

	assign rdata = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

[hw/rtl/tlr_ctrl.sv]
// ----------------------------------------------------------------------------
// Thin line removal control
// Configuration registers, row and column counters, per-item decode and
// line buffer read addresses for the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_ctrl #(
	parameter int MAX_WIDTH = tlr_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [tlr_pkg::CFG_ADDR_W-1:0]    wr_index,
	input  wire logic [tlr_pkg::CFG_DATA_W-1:0]    wr_data,
	input  wire logic                              accept,
	input  wire logic                              action,
	output tlr_pkg::tlr_step_t                     step,
	output logic      [$clog2(MAX_WIDTH)-1:0]      col,
	output logic      [$clog2(MAX_WIDTH)-1:0]      rd_addr,
	output logic      [$clog2(MAX_WIDTH)-1:0]      rd_addr_right
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int XW    = (WB > tlr_pkg::WIDTH_REG_W) ? WB : tlr_pkg::WIDTH_REG_W;

	logic [tlr_pkg::WIDTH_REG_W-1:0] width_q;
	logic [tlr_pkg::HEIGHT_W-1:0]    height_q;
	logic                            enable_q;
	logic [COL_W-1:0]                col_q;
	logic [tlr_pkg::HEIGHT_W-1:0]    row_q;

	logic [XW-1:0]                   w_ext;
	logic [WB-1:0]                   w;
	logic [tlr_pkg::HEIGHT_W-1:0]    h;
	logic [WB-1:0]                   col_p1;
	logic                            last_col;
	logic                            row_lt_h;
	logic                            advance;
	logic [COL_W-1:0]                col_d;
	logic [tlr_pkg::HEIGHT_W-1:0]    row_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tlr_pkg::WIDTH_RST;
			height_q <= tlr_pkg::HEIGHT_RST;
			enable_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				tlr_pkg::REG_IMAGE_WIDTH:   width_q  <= wr_data[tlr_pkg::WIDTH_REG_W-1:0];
				tlr_pkg::REG_IMAGE_HEIGHT:  height_q <= wr_data[tlr_pkg::HEIGHT_W-1:0];
				tlr_pkg::REG_FILTER_ENABLE: enable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_ext = XW'(width_q);
		if (width_q == '0) begin
			w = WB'(1);
		end else if (w_ext > XW'(MAX_WIDTH)) begin
			w = WB'(MAX_WIDTH);
		end else begin
			w = WB'(w_ext);
		end
		h = (height_q == '0) ? tlr_pkg::HEIGHT_W'(1) : height_q;

		col      = (WB'(col_q) >= w) ? COL_W'(w - WB'(1)) : col_q;
		col_p1   = WB'(col) + WB'(1);
		last_col = (col_p1 >= w);
		row_lt_h = (row_q < h);

		step          = '0;
		step.interior = enable_q && (col != '0) && (col_p1 < w);
		if (action == tlr_pkg::ACT_PIXEL) begin
			step.wr_raw  = row_lt_h;
			step.produce = row_lt_h && (row_q != '0);
			step.vert    = (row_q >= tlr_pkg::HEIGHT_W'(2));
		end else begin
			step.produce = !row_lt_h;
			step.eoi     = last_col;
		end
		advance = step.produce || step.wr_raw;

		col_d = col_q;
		row_d = row_q;
		if (accept && advance) begin
			col_d = last_col ? '0 : COL_W'(col_p1);
			if (last_col) begin
				row_d = (action == tlr_pkg::ACT_PIXEL) ? row_q + tlr_pkg::HEIGHT_W'(1) : '0;
			end
		end

		rd_addr       = (WB'(col_d) >= w) ? COL_W'(w - WB'(1)) : col_d;
		rd_addr_right = rd_addr + COL_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/thin_line_removal_filter.sv]
// ----------------------------------------------------------------------------
// Thin line removal filter
// Raster-order RGB filter that removes one-pixel-thin lines.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_stream carries items: action 0 delivers a pixel, action 1 drains
//   one pixel of the final row once every row has been received.
//   result_stream returns filtered pixels; end_of_image marks the last one.
//   Output lags input by one row: the first row gives no results, each later
//   pixel releases the pixel above it, and one drain item per column flushes
//   the last row. Pixels after the final row and early drains are dropped.
//   One item is taken every cycle while ready is high; a result is registered
//   and appears in the cycle after its item. The rate is set by the line
//   buffers, read ahead of the item at the column the counters predict.
//   A write on the wr_en/wr_index/wr_data port holds ready low for the next
//   cycle while the buffer reads follow the new size.
//   Reset clears counters and the left neighbour register and restores the
//   register defaults; line buffer contents are not cleared.
//   While result_stream stalls the result register holds and ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module thin_line_removal_filter #(
	parameter int MAX_WIDTH = tlr_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [tlr_pkg::CFG_ADDR_W-1:0] wr_index,
	input  wire logic [tlr_pkg::CFG_DATA_W-1:0] wr_data,
	tlr_in_if.sink                              pixel_stream,
	tlr_out_if.source                           result_stream
);

`include "thin_line_removal_filter_assert.svh"

	localparam int COL_W = $clog2(MAX_WIDTH);

	tlr_pkg::tlr_step_t            step;
	logic [COL_W-1:0]              col;
	logic [COL_W-1:0]              rd_addr;
	logic [COL_W-1:0]              rd_addr_right;
	logic                          cfg_wait_q;
	logic                          ready;
	logic                          acc;
	logic [tlr_pkg::COLOR_W-1:0]   cur;
	logic [tlr_pkg::COLOR_W-1:0]   right;
	logic [tlr_pkg::COLOR_W-1:0]   above;
	logic [tlr_pkg::COLOR_W-1:0]   res;
	logic [tlr_pkg::COLOR_W-1:0]   left_q;
	logic                          out_valid_q;
	logic [tlr_pkg::COLOR_W-1:0]   out_color_q;
	logic                          eoi_q;

	tlr_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.accept        (acc),
		.action        (pixel_stream.action),
		.step          (step),
		.col           (col),
		.rd_addr       (rd_addr),
		.rd_addr_right (rd_addr_right)
	);

	tlr_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(tlr_pkg::COLOR_W)) u_raw_cur (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (acc && step.wr_raw),
		.waddr  (col),
		.wdata  (pixel_stream.pixel_color),
		.raddr  (rd_addr),
		.rdata  (cur)
	);

	tlr_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(tlr_pkg::COLOR_W)) u_raw_right (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (acc && step.wr_raw),
		.waddr  (col),
		.wdata  (pixel_stream.pixel_color),
		.raddr  (rd_addr_right),
		.rdata  (right)
	);

	tlr_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(tlr_pkg::COLOR_W)) u_filtered (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (acc && step.produce),
		.waddr  (col),
		.wdata  (res),
		.raddr  (rd_addr),
		.rdata  (above)
	);

	assign ready = !cfg_wait_q && (!out_valid_q || result_stream.ready);
	assign acc   = pixel_stream.valid && ready;

	always_comb begin
		res = cur;
		if (step.interior) begin
			if ((cur != left_q) && (cur != right)) begin
				res = left_q;
			end
			if (step.vert && (cur != pixel_stream.pixel_color) && (cur != above)) begin
				res = pixel_stream.pixel_color;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_wait_q  <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			cfg_wait_q <= wr_en;
			if (!out_valid_q || result_stream.ready) begin
				out_valid_q <= acc && step.produce;
			end
			if (acc && step.produce) begin
				left_q <= step.eoi ? '0 : res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && step.produce) begin
			out_color_q <= res;
			eoi_q       <= step.eoi;
		end
	end

	assign pixel_stream.ready        = ready;
	assign result_stream.valid       = out_valid_q;
	assign result_stream.out_color   = out_color_q;
	assign result_stream.end_of_image = eoi_q;

	`TLR_ASSERT_NXT(a_cfg_blocks_input, clk, arst_n, wr_en, !pixel_stream.ready)
	`TLR_ASSERT_NXT(a_no_spurious_result, clk, arst_n, acc && !step.produce, !out_valid_q)
	`TLR_ASSERT_NXT(a_image_end_clears_left, clk, arst_n, acc && step.produce && step.eoi, left_q == '0)
	`TLR_ASSERT_IMP(a_eoi_only_on_drain, clk, arst_n, acc && step.eoi, pixel_stream.action == tlr_pkg::ACT_DRAIN)

endmodule

`default_nettype wire

[dv/tb_thin_line_removal_filter.sv]
// ----------------------------------------------------------------------------
// Thin line removal filter testbench
// A short directed table comes first: it covers reset defaults, thin line
// removal, the first and final rows, early drains, late pixels, clamped sizes
// and the vertical override. Then sizes are shrunk in mid-image, the output is
// held off for a long stretch while pixels keep coming, and random images
// follow. Each result is compared with the table's value or with a cycle-free
// predictor of the filter and its line buffers.
// ----------------------------------------------------------------------------
module tb_thin_line_removal_filter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W        = tlr_pkg::MAX_WIDTH_DEF;
	localparam int TARGET_ITEMS = 640;
	localparam int CALM_ITEMS   = 540;

	typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_GIVEN} check_mode_t;
	typedef enum logic [1:0] {STEP_IGNORED, STEP_STORED, STEP_EMITTED} step_kind_t;
	typedef enum logic [2:0] {
		ROW_SET_WIDTH, ROW_SET_HEIGHT, ROW_SET_ENABLE, ROW_PIXEL, ROW_DRAIN
	} row_op_t;

	typedef struct packed {
		logic [tlr_pkg::COLOR_W-1:0] color;
		logic                        eoi;
	} pixel_out_t;

	typedef struct packed {
		row_op_t                     op;
		logic [tlr_pkg::COLOR_W-1:0] value;
		check_mode_t                 mode;
		logic [tlr_pkg::COLOR_W-1:0] exp_color;
		logic                        exp_eoi;
	} dir_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           wr_en;
	logic [tlr_pkg::CFG_ADDR_W-1:0] wr_index;
	logic [tlr_pkg::CFG_DATA_W-1:0] wr_data;

	tlr_in_if  pixel_stream ();
	tlr_out_if result_stream ();

	thin_line_removal_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.pixel_stream (pixel_stream),
		.result_stream(result_stream)
	);

	logic [tlr_pkg::COLOR_W-1:0]     row_raw [MAX_W];
	logic [tlr_pkg::COLOR_W-1:0]     row_clean [MAX_W];
	logic [tlr_pkg::COLOR_W-1:0]     left_clean = '0;
	int                              col_ptr = 0;
	int                              row_ptr = 0;
	logic [tlr_pkg::WIDTH_REG_W-1:0] cfg_width = tlr_pkg::WIDTH_RST;
	logic [tlr_pkg::HEIGHT_W-1:0]    cfg_height = tlr_pkg::HEIGHT_RST;
	logic                            cfg_filter = 1'b1;

	pixel_out_t                  awaited_pixels [$];
	pixel_out_t                  got_pixel;
	pixel_out_t                  want_pixel;
	logic [tlr_pkg::COLOR_W-1:0] palette [4];
	int                          mismatch_count = 0;
	int                          taken_items = 0;
	int                          hold_cycles = 0;
	bit                          idle_on = 1'b1;

	dir_row_t directed_rows [33] = '{
		'{ROW_DRAIN,      24'h000000, EXP_NONE,  24'h000000, 1'b0},
		'{ROW_SET_WIDTH,  24'd3,      EXP_NONE,  24'h000000, 1'b0},
		'{ROW_SET_HEIGHT, 24'd2,      EXP_NONE,  24'h000000, 1'b0},
		'{ROW_SET_ENABLE, 24'd1,      EXP_NONE,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h000000, EXP_NONE,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'hFFFFFF, EXP_NONE,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h000000, EXP_NONE,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'hFFFFFF, EXP_GIVEN, 24'h000000, 1'b0},
		'{ROW_PIXEL,      24'hFFFFFF, EXP_GIVEN, 24'h000000, 1'b0},
		'{ROW_PIXEL,      24'hFFFFFF, EXP_GIVEN, 24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h00FF00, EXP_NONE,  24'h000000, 1'b0},
		'{ROW_DRAIN,      24'h000000, EXP_GIVEN, 24'hFFFFFF, 1'b0},
		'{ROW_DRAIN,      24'h000000, EXP_GIVEN, 24'hFFFFFF, 1'b0},
		'{ROW_DRAIN,      24'h000000, EXP_GIVEN, 24'hFFFFFF, 1'b1},
		'{ROW_SET_WIDTH,  24'd1,      EXP_NONE,  24'h000000, 1'b0},
		'{ROW_SET_HEIGHT, 24'd0,      EXP_NONE,  24'h000000, 1'b0},
		'{ROW_DRAIN,      24'h000000, EXP_NONE,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h123456, EXP_NONE,  24'h000000, 1'b0},
		'{ROW_DRAIN,      24'h000000, EXP_GIVEN, 24'h123456, 1'b1},
		'{ROW_SET_WIDTH,  24'd3,      EXP_NONE,  24'h000000, 1'b0},
		'{ROW_SET_HEIGHT, 24'd3,      EXP_NONE,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h555555, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h555555, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h555555, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h333333, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h222222, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h777777, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h999999, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h999999, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_PIXEL,      24'h999999, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_DRAIN,      24'h000000, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_DRAIN,      24'h000000, EXP_PRED,  24'h000000, 1'b0},
		'{ROW_DRAIN,      24'h000000, EXP_PRED,  24'h000000, 1'b0}
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int eff_width();
		if (cfg_width < 1) return 1;
		if (cfg_width > MAX_W) return MAX_W;
		return int'(cfg_width);
	endfunction

	function automatic int eff_height();
		return (cfg_height == 0) ? 1 : int'(cfg_height);
	endfunction

	function automatic logic [tlr_pkg::COLOR_W-1:0] clean_pixel(input int col, input int w,
			input bit vert, input logic [tlr_pkg::COLOR_W-1:0] below);
		logic [tlr_pkg::COLOR_W-1:0] orig;
		logic [tlr_pkg::COLOR_W-1:0] res;
		orig = row_raw[col];
		res  = orig;
		if (cfg_filter && col >= 1 && col + 1 < w) begin
			if (orig != left_clean && orig != row_raw[col + 1]) res = left_clean;
			if (vert && orig != below && orig != row_clean[col]) res = below;
		end
		row_clean[col] = res;
		left_clean     = res;
		return res;
	endfunction

	function automatic step_kind_t filter_item(input logic act,
			input logic [tlr_pkg::COLOR_W-1:0] pix, output pixel_out_t result);
		int         w;
		int         h;
		int         col;
		bit         last_col;
		step_kind_t kind;
		w        = eff_width();
		h        = eff_height();
		col      = (col_ptr >= w) ? w - 1 : col_ptr;
		last_col = (col + 1 >= w);
		result   = '0;
		kind     = STEP_IGNORED;
		if (act == tlr_pkg::ACT_PIXEL) begin
			if (row_ptr < h) begin
				kind = STEP_STORED;
				if (row_ptr >= 1) begin
					result.color = clean_pixel(col, w, row_ptr >= 2, pix);
					kind         = STEP_EMITTED;
				end
				row_raw[col] = pix;
				if (last_col) begin
					col_ptr = 0;
					row_ptr = (row_ptr + 1) % 65536;
				end else begin
					col_ptr = col + 1;
				end
			end
		end else if (row_ptr >= h) begin
			result.color = clean_pixel(col, w, 1'b0, '0);
			kind         = STEP_EMITTED;
			if (last_col) begin
				result.eoi = 1'b1;
				col_ptr    = 0;
				row_ptr    = 0;
				left_clean = '0;
			end else begin
				col_ptr = col + 1;
			end
		end
		return kind;
	endfunction

	task automatic push_item(input logic act, input logic [tlr_pkg::COLOR_W-1:0] pix,
			input check_mode_t mode = EXP_PRED, input pixel_out_t given = '0);
		pixel_out_t predicted;
		step_kind_t kind;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			pixel_stream.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		pixel_stream.valid       <= 1'b1;
		pixel_stream.action      <= act;
		pixel_stream.pixel_color <= pix;
		do @(posedge clk); while (!pixel_stream.ready);
		kind = filter_item(act, pix, predicted);
		if (kind != STEP_IGNORED) taken_items++;
		if (mode == EXP_GIVEN) awaited_pixels = {awaited_pixels, given};
		else if (mode == EXP_PRED && kind == STEP_EMITTED)
			awaited_pixels = {awaited_pixels, predicted};
		@(negedge clk);
	endtask

	task automatic settle();
		pixel_stream.valid <= 1'b0;
		while (awaited_pixels.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [tlr_pkg::CFG_ADDR_W-1:0] idx,
			input logic [tlr_pkg::CFG_DATA_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			tlr_pkg::REG_IMAGE_WIDTH:   cfg_width = val[tlr_pkg::WIDTH_REG_W-1:0];
			tlr_pkg::REG_IMAGE_HEIGHT:  cfg_height = val[tlr_pkg::HEIGHT_W-1:0];
			tlr_pkg::REG_FILTER_ENABLE: cfg_filter = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic configure(input int w_reg, input int h_reg, input logic en);
		settle();
		write_reg(tlr_pkg::REG_IMAGE_WIDTH, tlr_pkg::CFG_DATA_W'(w_reg));
		write_reg(tlr_pkg::REG_IMAGE_HEIGHT, tlr_pkg::CFG_DATA_W'(h_reg));
		write_reg(tlr_pkg::REG_FILTER_ENABLE, tlr_pkg::CFG_DATA_W'(en));
		foreach (palette[i]) palette[i] = tlr_pkg::COLOR_W'($urandom);
	endtask

	task automatic send_pixels(input int n);
		repeat (n) push_item(tlr_pkg::ACT_PIXEL, ($urandom_range(0, 7) == 0) ?
			tlr_pkg::COLOR_W'($urandom) : palette[$urandom_range(0, 3)]);
	endtask

	task automatic run_image(input int w_reg, input int h_reg, input logic en, input bit noisy);
		configure(w_reg, h_reg, en);
		for (int p = 0; p < eff_width() * eff_height(); p++) begin
			if (noisy && $urandom_range(0, 40) == 0)
				push_item(tlr_pkg::ACT_DRAIN, tlr_pkg::COLOR_W'($urandom));
			send_pixels(1);
		end
		if (noisy && $urandom_range(0, 2) == 0) send_pixels($urandom_range(1, 2));
		repeat (eff_width()) push_item(tlr_pkg::ACT_DRAIN, tlr_pkg::COLOR_W'($urandom));
	endtask

	initial begin
		result_stream.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_stream.ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
				result_stream.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				result_stream.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				result_stream.ready <= 1'b1;
			end else begin
				result_stream.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_stream.valid && result_stream.ready) begin
			got_pixel = '{result_stream.out_color, result_stream.end_of_image};
			if (awaited_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result: color %06h eoi %0b",
						$realtime, got_pixel.color, got_pixel.eoi);
			end else begin
				want_pixel = awaited_pixels.pop_front();
				if (got_pixel.color !== want_pixel.color || got_pixel.eoi !== want_pixel.eoi) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch: expected color %06h eoi %0b, got color %06h eoi %0b",
							$realtime, want_pixel.color, want_pixel.eoi,
							got_pixel.color, got_pixel.eoi);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		dir_row_t row;
		int       sel;
		int       w_reg;
		int       h_reg;
		arst_n                   = 1'b0;
		wr_en                    = 1'b0;
		wr_index                 = tlr_pkg::REG_IMAGE_WIDTH;
		wr_data                  = '0;
		pixel_stream.valid       = 1'b0;
		pixel_stream.action      = tlr_pkg::ACT_PIXEL;
		pixel_stream.pixel_color = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.op)
				ROW_SET_WIDTH: begin
					settle();
					write_reg(tlr_pkg::REG_IMAGE_WIDTH, row.value[tlr_pkg::CFG_DATA_W-1:0]);
				end
				ROW_SET_HEIGHT: begin
					settle();
					write_reg(tlr_pkg::REG_IMAGE_HEIGHT, row.value[tlr_pkg::CFG_DATA_W-1:0]);
				end
				ROW_SET_ENABLE: begin
					settle();
					write_reg(tlr_pkg::REG_FILTER_ENABLE, row.value[tlr_pkg::CFG_DATA_W-1:0]);
				end
				ROW_PIXEL: push_item(tlr_pkg::ACT_PIXEL, row.value, row.mode,
					'{row.exp_color, row.exp_eoi});
				default:   push_item(tlr_pkg::ACT_DRAIN, row.value, row.mode,
					'{row.exp_color, row.exp_eoi});
			endcase
		end

		// shrink the height, then the width, part way through an image
		configure(6, 4, 1'b1);
		send_pixels(18);
		settle();
		write_reg(tlr_pkg::REG_IMAGE_HEIGHT, 16'd2);
		repeat (6) push_item(tlr_pkg::ACT_DRAIN, tlr_pkg::COLOR_W'($urandom));
		configure(8, 4, 1'b1);
		send_pixels(21);
		settle();
		write_reg(tlr_pkg::REG_IMAGE_WIDTH, 16'd4);
		send_pixels(5);
		repeat (4) push_item(tlr_pkg::ACT_DRAIN, tlr_pkg::COLOR_W'($urandom));

		// hold off the output while pixels keep coming
		configure(20, 3, 1'b1);
		hold_cycles = 300;
		send_pixels(60);
		repeat (20) push_item(tlr_pkg::ACT_DRAIN, tlr_pkg::COLOR_W'($urandom));

		taken_items = 0;
		while (taken_items < TARGET_ITEMS) begin
			sel   = $urandom_range(0, 19);
			w_reg = (sel == 0) ? $urandom_range(0, 2) :
				(sel == 1) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			h_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			idle_on = (taken_items < CALM_ITEMS) && ($urandom_range(0, 3) != 0);
			run_image(w_reg, h_reg, $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0);
		end

		pixel_stream.valid <= 1'b0;
		while (awaited_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
